[src/llnpe_pkg.sv]
// shared constants, types and the control store of the linked list engine
`default_nettype none

package llnpe_pkg;

	localparam int POOL_NODES_DEF = 64;
	localparam int CMD_W = 3;
	localparam int NODE_W = 6;
	localparam int BC_W = 7;
	localparam int ST_W = 2;
	localparam int CNT_W = 7;
	localparam int COUNT_MAX = 127;
	localparam int UPC_W = 5;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP = 3'd4;
	localparam logic [CMD_W-1:0] CMD_QUERY = 3'd5;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_HEAD,
		RD_CUR
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_TAIL_NODE,
		WR_NODE_NIL,
		WR_HEAD_NIL,
		WR_PREV_LINK,
		WR_CUR_NIL,
		WR_BUILD
	} wr_sel_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_APPEND,
		OP_UNHEAD,
		OP_WALK_INIT,
		OP_LOAD_CUR,
		OP_ADVANCE,
		OP_FOUND,
		OP_ST_EMPTY,
		OP_ST_NOT_FOUND,
		OP_BUILD_INIT,
		OP_BUILD_STEP,
		OP_BUILD_END
	} reg_op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_HEAD_NIL,
		C_NODE_BAD,
		C_APP_NOLINK,
		C_HEAD_IS_NODE,
		C_CUR_END,
		C_CUR_MATCH,
		C_BUILD_DONE
	} cond_t;

	typedef struct packed {
		rd_sel_t rd;
		wr_sel_t wr;
		reg_op_t op;
		cond_t   cond;
		upc_t    target;
		logic    last;
	} uword_t;

	localparam upc_t U_CLEAR = 5'd0;
	localparam upc_t U_QUERY = 5'd1;
	localparam upc_t U_APP0 = 5'd2;
	localparam upc_t U_APP1 = 5'd3;
	localparam upc_t U_APP2 = 5'd4;
	localparam upc_t U_APP3 = 5'd5;
	localparam upc_t U_POP0 = 5'd6;
	localparam upc_t U_POP1 = 5'd7;
	localparam upc_t U_POP2 = 5'd8;
	localparam upc_t U_EMPTY = 5'd9;
	localparam upc_t U_REM0 = 5'd10;
	localparam upc_t U_REM1 = 5'd11;
	localparam upc_t U_REM2 = 5'd12;
	localparam upc_t U_REM3 = 5'd13;
	localparam upc_t U_REM4 = 5'd14;
	localparam upc_t U_REM5 = 5'd15;
	localparam upc_t U_REM6 = 5'd16;
	localparam upc_t U_REM7 = 5'd17;
	localparam upc_t U_REM8 = 5'd18;
	localparam upc_t U_REM9 = 5'd19;
	localparam upc_t U_NOTF = 5'd20;
	localparam upc_t U_BLD0 = 5'd21;
	localparam upc_t U_BLD1 = 5'd22;
	localparam upc_t U_BLD2 = 5'd23;
	localparam upc_t U_BLD3 = 5'd24;

	function automatic uword_t mk(rd_sel_t rd, wr_sel_t wr, reg_op_t op, cond_t cond,
			upc_t target, logic last);
		uword_t w;
		w.rd = rd;
		w.wr = wr;
		w.op = op;
		w.cond = cond;
		w.target = target;
		w.last = last;
		return w;
	endfunction

	function automatic upc_t entry_of(logic [CMD_W-1:0] c);
		upc_t u;
		case (c)
			CMD_CLEAR:  u = U_CLEAR;
			CMD_BUILD:  u = U_BLD0;
			CMD_APPEND: u = U_APP0;
			CMD_REMOVE: u = U_REM0;
			CMD_POP:    u = U_POP0;
			default:    u = U_QUERY;
		endcase
		return u;
	endfunction

	function automatic uword_t ucode(upc_t upc);
		uword_t w;
		case (upc)
			U_CLEAR: w = mk(RD_NONE, WR_NONE, OP_CLEAR, C_NEVER, U_CLEAR, 1'b1);
			U_QUERY: w = mk(RD_NONE, WR_NONE, OP_NONE, C_NEVER, U_QUERY, 1'b1);
			U_APP0:  w = mk(RD_NONE, WR_NONE, OP_NONE, C_NODE_BAD, U_QUERY, 1'b0);
			U_APP1:  w = mk(RD_NONE, WR_NONE, OP_NONE, C_APP_NOLINK, U_APP3, 1'b0);
			U_APP2:  w = mk(RD_NONE, WR_TAIL_NODE, OP_NONE, C_NEVER, U_APP2, 1'b0);
			U_APP3:  w = mk(RD_NONE, WR_NODE_NIL, OP_APPEND, C_NEVER, U_APP3, 1'b1);
			U_POP0:  w = mk(RD_NONE, WR_NONE, OP_NONE, C_HEAD_NIL, U_EMPTY, 1'b0);
			U_POP1:  w = mk(RD_HEAD, WR_NONE, OP_NONE, C_NEVER, U_POP1, 1'b0);
			U_POP2:  w = mk(RD_NONE, WR_HEAD_NIL, OP_UNHEAD, C_NEVER, U_POP2, 1'b1);
			U_EMPTY: w = mk(RD_NONE, WR_NONE, OP_ST_EMPTY, C_NEVER, U_EMPTY, 1'b1);
			U_REM0:  w = mk(RD_NONE, WR_NONE, OP_NONE, C_HEAD_NIL, U_EMPTY, 1'b0);
			U_REM1:  w = mk(RD_NONE, WR_NONE, OP_WALK_INIT, C_HEAD_IS_NODE, U_POP1, 1'b0);
			U_REM2:  w = mk(RD_HEAD, WR_NONE, OP_NONE, C_NEVER, U_REM2, 1'b0);
			U_REM3:  w = mk(RD_NONE, WR_NONE, OP_LOAD_CUR, C_NEVER, U_REM3, 1'b0);
			U_REM4:  w = mk(RD_NONE, WR_NONE, OP_NONE, C_CUR_END, U_NOTF, 1'b0);
			U_REM5:  w = mk(RD_NONE, WR_NONE, OP_NONE, C_CUR_MATCH, U_REM7, 1'b0);
			U_REM6:  w = mk(RD_CUR, WR_NONE, OP_ADVANCE, C_ALWAYS, U_REM3, 1'b0);
			U_REM7:  w = mk(RD_CUR, WR_NONE, OP_NONE, C_NEVER, U_REM7, 1'b0);
			U_REM8:  w = mk(RD_NONE, WR_PREV_LINK, OP_NONE, C_NEVER, U_REM8, 1'b0);
			U_REM9:  w = mk(RD_NONE, WR_CUR_NIL, OP_FOUND, C_NEVER, U_REM9, 1'b1);
			U_NOTF:  w = mk(RD_NONE, WR_NONE, OP_ST_NOT_FOUND, C_NEVER, U_NOTF, 1'b1);
			U_BLD0:  w = mk(RD_NONE, WR_NONE, OP_BUILD_INIT, C_NEVER, U_BLD0, 1'b0);
			U_BLD1:  w = mk(RD_NONE, WR_NONE, OP_NONE, C_BUILD_DONE, U_BLD3, 1'b0);
			U_BLD2:  w = mk(RD_NONE, WR_BUILD, OP_BUILD_STEP, C_ALWAYS, U_BLD1, 1'b0);
			U_BLD3:  w = mk(RD_NONE, WR_NONE, OP_BUILD_END, C_NEVER, U_BLD3, 1'b1);
			default: w = mk(RD_NONE, WR_NONE, OP_NONE, C_NEVER, U_QUERY, 1'b1);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[src/llnpe_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module llnpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/linked_list_node_pool_engine_core.sv]
// singly linked list queue over a node pool, run by a microcoded sequencer
`default_nettype none

// One command is taken when start is high and busy is low; busy stays high while the
// sequencer runs its microprogram, and the result appears for exactly one cycle with
// done high, the cycle after the last step, with busy already low so the next command
// can be taken in that same cycle. The next-link memory has one port each for read and
// write with a registered read. Pop ends early on an empty list; remove ends early on an
// empty list or when the head is the target, else walks the links (at most POOL_NODES
// of them) until it finds or misses the target; build writes one link per chained node.
// The result cannot be held off: it is gone after its cycle.
module linked_list_node_pool_engine_core
	import llnpe_pkg::*;
#(
	parameter int POOL_NODES = POOL_NODES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [NODE_W-1:0] node,
	input  wire logic [BC_W-1:0]   build_count,
	output logic                   done,
	output logic [ST_W-1:0]        status,
	output logic [NODE_W-1:0]      popped_node,
	output logic                   popped_valid,
	output logic [NODE_W-1:0]      first_node,
	output logic                   first_valid,
	output logic [CNT_W-1:0]       node_count
);

	localparam int LW = $clog2(POOL_NODES + 1);
	localparam int AW = $clog2(POOL_NODES);
	localparam int CW = (LW > CNT_W) ? LW : CNT_W;
	localparam int MW = (LW > NODE_W) ? LW : NODE_W;
	localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

	logic              running_q;
	logic              done_q;
	upc_t              upc_q;
	logic [NODE_W-1:0] node_q;
	logic [BC_W-1:0]   bc_q;
	logic              is_pop_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic [LW-1:0]     prev_q;
	logic [LW-1:0]     cur_q;
	logic [LW-1:0]     steps_q;
	logic [LW-1:0]     i_q;
	logic [LW-1:0]     n_q;
	logic [ST_W-1:0]   status_q;
	logic [NODE_W-1:0] popped_q;
	logic              pvalid_q;

	logic          accept;
	uword_t        uw;
	logic          cond_hit;
	upc_t          upc_next;
	logic          head_is_node;
	logic          tail_is_node;
	logic          cur_is_node;
	logic          node_ok;
	logic [LW-1:0] node_ext;
	logic [LW-1:0] i_inc;
	logic [LW-1:0] build_n;
	logic [CW-1:0] count_dec;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [LW-1:0] ram_rdata;

	assign accept = start && !busy;
	assign uw = ucode(upc_q);

	assign head_is_node = head_q < NIL;
	assign tail_is_node = tail_q < NIL;
	assign cur_is_node = cur_q < NIL;
	assign node_ok = int'(node_q) < POOL_NODES;
	assign node_ext = LW'(node_q);
	assign i_inc = i_q + LW'(1);
	assign build_n = (int'(bc_q) > POOL_NODES) ? NIL : LW'(bc_q);
	assign count_dec = (count_q != '0) ? count_q - CW'(1) : count_q;

	always_comb begin
		case (uw.cond)
			C_NEVER:        cond_hit = 1'b0;
			C_ALWAYS:       cond_hit = 1'b1;
			C_HEAD_NIL:     cond_hit = !head_is_node;
			C_NODE_BAD:     cond_hit = !node_ok;
			C_APP_NOLINK:   cond_hit = !head_is_node || !tail_is_node;
			C_HEAD_IS_NODE: cond_hit = node_ok && (MW'(head_q) == MW'(node_q));
			C_CUR_END:      cond_hit = !cur_is_node || (steps_q >= NIL);
			C_CUR_MATCH:    cond_hit = MW'(cur_q) == MW'(node_q);
			C_BUILD_DONE:   cond_hit = i_q >= n_q;
			default:        cond_hit = 1'b0;
		endcase
		upc_next = cond_hit ? uw.target : upc_q + upc_t'(1);
	end

	always_comb begin
		ram_re = running_q && (uw.rd != RD_NONE);
		ram_raddr = (uw.rd == RD_CUR) ? cur_q[AW-1:0] : head_q[AW-1:0];
		ram_we = running_q;
		ram_waddr = head_q[AW-1:0];
		ram_wdata = NIL;
		case (uw.wr)
			WR_TAIL_NODE: begin
				ram_waddr = tail_q[AW-1:0];
				ram_wdata = node_ext;
			end
			WR_NODE_NIL: begin
				ram_waddr = node_ext[AW-1:0];
			end
			WR_HEAD_NIL: begin
				ram_waddr = head_q[AW-1:0];
			end
			WR_PREV_LINK: begin
				ram_waddr = prev_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			WR_CUR_NIL: begin
				ram_waddr = cur_q[AW-1:0];
			end
			WR_BUILD: begin
				// last node of the build closes the chain
				ram_waddr = i_q[AW-1:0];
				ram_wdata = (i_inc < n_q) ? i_inc : NIL;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	llnpe_ram #(
		.WIDTH(LW),
		.DEPTH(POOL_NODES)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			upc_q <= U_QUERY;
			head_q <= NIL;
			tail_q <= NIL;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				running_q <= 1'b1;
				upc_q <= entry_of(cmd);
			end else if (running_q) begin
				upc_q <= upc_next;
				if (uw.last) begin
					running_q <= 1'b0;
					done_q <= 1'b1;
				end
				case (uw.op)
					OP_CLEAR: begin
						head_q <= NIL;
						tail_q <= NIL;
						count_q <= '0;
					end
					OP_APPEND: begin
						if (!head_is_node) begin
							head_q <= node_ext;
						end
						tail_q <= node_ext;
						if (count_q < CW'(COUNT_MAX)) begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_UNHEAD: begin
						if (head_q == tail_q) begin
							head_q <= NIL;
							tail_q <= NIL;
						end else begin
							head_q <= ram_rdata;
						end
						count_q <= count_dec;
					end
					OP_FOUND: begin
						if (MW'(tail_q) == MW'(node_q)) begin
							tail_q <= prev_q;
						end
						count_q <= count_dec;
					end
					OP_BUILD_END: begin
						if (n_q == '0) begin
							head_q <= NIL;
							tail_q <= NIL;
						end else begin
							head_q <= '0;
							tail_q <= n_q - LW'(1);
						end
						count_q <= CW'(n_q);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// command fields, walk pointers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			node_q <= node;
			bc_q <= build_count;
			is_pop_q <= cmd == CMD_POP;
			status_q <= ST_OK;
			popped_q <= '0;
			pvalid_q <= 1'b0;
		end else if (running_q) begin
			case (uw.op)
				OP_UNHEAD: begin
					if (is_pop_q) begin
						popped_q <= NODE_W'(head_q);
						pvalid_q <= 1'b1;
					end
				end
				OP_WALK_INIT: begin
					prev_q <= head_q;
					steps_q <= '0;
				end
				OP_LOAD_CUR: begin
					cur_q <= ram_rdata;
				end
				OP_ADVANCE: begin
					prev_q <= cur_q;
					steps_q <= steps_q + LW'(1);
				end
				OP_ST_EMPTY: begin
					status_q <= ST_EMPTY;
				end
				OP_ST_NOT_FOUND: begin
					status_q <= ST_NOT_FOUND;
				end
				OP_BUILD_INIT: begin
					i_q <= '0;
					n_q <= build_n;
				end
				OP_BUILD_STEP: begin
					i_q <= i_inc;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = running_q;
	assign done = done_q;
	assign status = status_q;
	assign popped_node = popped_q;
	assign popped_valid = pvalid_q;
	assign first_valid = head_is_node;
	assign first_node = head_is_node ? NODE_W'(head_q) : '0;
	assign node_count = CNT_W'(count_q);

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the sequencer runs");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted command did not start the sequencer");

	a_one_ram_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("read and write issued in one step");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && popped_valid |-> status == ST_OK)
		else $error("popped node reported with a failure status");

endmodule

`default_nettype wire

[verif/tb_linked_list_node_pool_engine_core.sv]
// testbench for the linked list node pool engine: directed table, then random command traffic
`timescale 1ns / 1ps

module tb_linked_list_node_pool_engine_core;
	import llnpe_pkg::*;

	localparam logic [6:0] NIL_LINK = 7'(POOL_NODES_DEF);
	localparam int RANDOM_ITEMS = 1625;
	localparam int TAIL_CALM = 150;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [NODE_W-1:0] node;
		logic [BC_W-1:0]   build_count;
	} cmd_item_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [NODE_W-1:0] popped_node;
		logic              popped_valid;
		logic [NODE_W-1:0] first_node;
		logic              first_valid;
		logic [CNT_W-1:0]  node_count;
	} list_result_t;

	typedef struct packed {
		cmd_item_t    item;
		logic         known;
		list_result_t res;
	} table_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CMD_W-1:0] cmd = CMD_QUERY;
	logic [NODE_W-1:0] node = '0;
	logic [BC_W-1:0] build_count = '0;
	logic busy;
	logic done;
	logic [ST_W-1:0] status;
	logic [NODE_W-1:0] popped_node;
	logic popped_valid;
	logic [NODE_W-1:0] first_node;
	logic first_valid;
	logic [CNT_W-1:0] node_count;

	// shadow of the list kept by the predictor
	logic [6:0] link_mem [POOL_NODES_DEF];
	logic [6:0] list_head = NIL_LINK;
	logic [6:0] list_tail = NIL_LINK;
	logic [6:0] list_len = '0;

	list_result_t pending_results[$];
	table_row_t stim_table[$];
	int mismatches = 0;
	int results_seen = 0;
	int n_builds = 0;
	int n_appends = 0;
	int n_removes = 0;
	int n_not_found = 0;
	int n_pops = 0;
	int n_empty = 0;
	int peak_len = 0;

	linked_list_node_pool_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.node(node),
		.build_count(build_count),
		.done(done),
		.status(status),
		.popped_node(popped_node),
		.popped_valid(popped_valid),
		.first_node(first_node),
		.first_valid(first_valid),
		.node_count(node_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		for (int i = 0; i < POOL_NODES_DEF; i++) link_mem[i] = '0;
	end

	function automatic bit valid_node(logic [6:0] v);
		return v < 7'(POOL_NODES_DEF);
	endfunction

	function automatic logic [6:0] next_of(logic [6:0] v);
		return valid_node(v) ? link_mem[v[5:0]] : NIL_LINK;
	endfunction

	function automatic void drop_head();
		logic [6:0] h;
		h = list_head;
		if (list_head == list_tail) begin
			list_head = NIL_LINK;
			list_tail = NIL_LINK;
		end else begin
			list_head = next_of(h);
		end
		if (valid_node(h)) link_mem[h[5:0]] = NIL_LINK;
		if (list_len > 0) list_len--;
	endfunction

	// advances the shadow list by one command and returns what the block should report
	function automatic list_result_t apply_command(cmd_item_t it);
		list_result_t r;
		logic [6:0] n;
		logic [6:0] prev;
		logic [6:0] cur;
		logic [6:0] target;
		int steps;
		bit found;
		r = '0;
		target = {1'b0, it.node};
		case (it.cmd)
			CMD_CLEAR: begin
				list_head = NIL_LINK;
				list_tail = NIL_LINK;
				list_len = '0;
			end
			CMD_BUILD: begin
				n = (it.build_count > 7'(POOL_NODES_DEF)) ? 7'(POOL_NODES_DEF) : it.build_count;
				for (int i = 0; i < n; i++) link_mem[i] = (i + 1 < n) ? 7'(i + 1) : NIL_LINK;
				if (n == 0) begin
					list_head = NIL_LINK;
					list_tail = NIL_LINK;
				end else begin
					list_head = '0;
					list_tail = n - 7'd1;
				end
				list_len = n;
			end
			CMD_APPEND: begin
				if (!valid_node(list_head)) begin
					list_head = target;
				end else if (valid_node(list_tail)) begin
					link_mem[list_tail[5:0]] = target;
				end
				list_tail = target;
				link_mem[it.node] = NIL_LINK;
				if (list_len < 7'(COUNT_MAX)) list_len++;
			end
			CMD_REMOVE: begin
				if (!valid_node(list_head)) begin
					r.status = ST_EMPTY;
				end else if (list_head == target) begin
					drop_head();
				end else begin
					prev = list_head;
					cur = next_of(prev);
					steps = 0;
					found = 1'b0;
					// walk is bounded so a corrupted chain still ends
					while (valid_node(cur) && steps < POOL_NODES_DEF && !found) begin
						if (cur == target) begin
							link_mem[prev[5:0]] = next_of(cur);
							link_mem[cur[5:0]] = NIL_LINK;
							if (list_tail == target) list_tail = prev;
							if (list_len > 0) list_len--;
							found = 1'b1;
						end else begin
							prev = cur;
							cur = next_of(cur);
							steps++;
						end
					end
					if (!found) r.status = ST_NOT_FOUND;
				end
			end
			CMD_POP: begin
				if (!valid_node(list_head)) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_node = list_head[5:0];
					r.popped_valid = 1'b1;
					drop_head();
				end
			end
			default: ;
		endcase
		r.first_valid = valid_node(list_head);
		r.first_node = valid_node(list_head) ? list_head[5:0] : '0;
		r.node_count = list_len;
		return r;
	endfunction

	// pick a node that is reachable from the head, so removes mostly hit
	function automatic logic [NODE_W-1:0] member_node();
		logic [NODE_W-1:0] seen[$];
		logic [6:0] walk;
		int steps = 0;
		walk = list_head;
		while (valid_node(walk) && steps < POOL_NODES_DEF) begin
			seen.push_back(walk[5:0]);
			walk = link_mem[walk[5:0]];
			steps++;
		end
		if (seen.size() == 0) return NODE_W'($urandom_range(0, 63));
		return seen[$urandom_range(0, seen.size() - 1)];
	endfunction

	function automatic cmd_item_t random_command();
		cmd_item_t it;
		int unsigned roll;
		it.node = NODE_W'($urandom_range(0, 63));
		it.build_count = BC_W'($urandom_range(0, 127));
		roll = $urandom_range(0, 99);
		if (roll < 34) begin
			it.cmd = CMD_APPEND;
		end else if (roll < 54) begin
			it.cmd = CMD_REMOVE;
			it.node = member_node();
		end else if (roll < 60) begin
			it.cmd = CMD_REMOVE;
		end else if (roll < 75) begin
			it.cmd = CMD_POP;
		end else if (roll < 80) begin
			it.cmd = CMD_QUERY;
		end else if (roll < 90) begin
			it.cmd = CMD_BUILD;
			// long builds are slow, keep most of them short
			if ($urandom_range(0, 9) != 0) it.build_count = BC_W'($urandom_range(0, 8));
		end else if (roll < 93) begin
			it.cmd = CMD_CLEAR;
		end else if (roll < 96) begin
			it.cmd = CMD_W'($urandom_range(6, 7));
		end else begin
			it.cmd = CMD_W'($urandom_range(0, 7));
		end
		return it;
	endfunction

	task automatic table_row(input logic [CMD_W-1:0] c, input int nd, input int bc,
			input logic known, input logic [ST_W-1:0] st, input int pn, input int pv,
			input int fn, input int fv, input int cnt);
		table_row_t row;
		row.item.cmd = c;
		row.item.node = NODE_W'(nd);
		row.item.build_count = BC_W'(bc);
		row.known = known;
		row.res.status = st;
		row.res.popped_node = NODE_W'(pn);
		row.res.popped_valid = 1'(pv);
		row.res.first_node = NODE_W'(fn);
		row.res.first_valid = 1'(fv);
		row.res.node_count = CNT_W'(cnt);
		stim_table.push_back(row);
	endtask

	// one command transfer: optional idle gap, then hold start until busy is low at an edge
	task automatic send_command(input cmd_item_t it, input int gap, input logic known,
			input list_result_t typed);
		list_result_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= it.cmd;
		node <= it.node;
		build_count <= it.build_count;
		do @(posedge clk); while (busy);
		predicted = apply_command(it);
		pending_results.push_back(known ? typed : predicted);
		case (it.cmd)
			CMD_BUILD:  n_builds++;
			CMD_APPEND: n_appends++;
			CMD_REMOVE: n_removes++;
			CMD_POP:    n_pops++;
			default: ;
		endcase
		if (predicted.status == ST_NOT_FOUND) n_not_found++;
		if (predicted.status == ST_EMPTY) n_empty++;
		if (int'(list_len) > peak_len) peak_len = list_len;
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatches++;
		$display("mismatch on result %0d, %s: got %0d expected %0d at %0t",
			results_seen, field, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (popped_node !== want.popped_node)
					report_mismatch("popped_node", popped_node, want.popped_node);
				if (popped_valid !== want.popped_valid)
					report_mismatch("popped_valid", popped_valid, want.popped_valid);
				if (first_node !== want.first_node)
					report_mismatch("first_node", first_node, want.first_node);
				if (first_valid !== want.first_valid)
					report_mismatch("first_valid", first_valid, want.first_valid);
				if (node_count !== want.node_count)
					report_mismatch("node_count", node_count, want.node_count);
			end
			results_seen++;
		end
	end

	initial begin
		cmd_item_t it;
		int gap;
		int append_run;
		bit idle_on;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_row(CMD_QUERY, 0, 0, 1, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_POP, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0, 0);
		table_row(CMD_REMOVE, 5, 0, 1, ST_EMPTY, 0, 0, 0, 0, 0);
		table_row(CMD_APPEND, 63, 0, 1, ST_OK, 0, 0, 63, 1, 1);
		table_row(CMD_APPEND, 0, 0, 1, ST_OK, 0, 0, 63, 1, 2);
		// tail removed through the walk
		table_row(CMD_REMOVE, 0, 0, 1, ST_OK, 0, 0, 63, 1, 1);
		table_row(CMD_REMOVE, 17, 0, 1, ST_NOT_FOUND, 0, 0, 63, 1, 1);
		table_row(CMD_REMOVE, 63, 0, 1, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_APPEND, 42, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_APPEND, 7, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_POP, 0, 0, 1, ST_OK, 42, 1, 7, 1, 1);
		table_row(CMD_BUILD, 0, 0, 1, ST_OK, 0, 0, 0, 0, 0);
		// count above the pool saturates
		table_row(CMD_BUILD, 0, 127, 1, ST_OK, 0, 0, 0, 1, 64);
		table_row(CMD_REMOVE, 63, 0, 1, ST_OK, 0, 0, 0, 1, 63);
		table_row(CMD_W'(6), 0, 0, 1, ST_OK, 0, 0, 0, 1, 63);
		table_row(CMD_W'(7), 63, 127, 1, ST_OK, 0, 0, 0, 1, 63);
		table_row(CMD_BUILD, 0, 64, 1, ST_OK, 0, 0, 0, 1, 64);
		table_row(CMD_REMOVE, 32, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_POP, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_BUILD, 0, 1, 1, ST_OK, 0, 0, 0, 1, 1);
		// appends, some of them of nodes already in the list
		table_row(CMD_APPEND, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_APPEND, 5, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_APPEND, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_REMOVE, 5, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_CLEAR, 21, 42, 1, ST_OK, 0, 0, 0, 0, 0);
		table_row(CMD_POP, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0, 0);

		foreach (stim_table[i])
			send_command(stim_table[i].item, 0, stim_table[i].known, stim_table[i].res);

		append_run = 0;
		idle_on = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
			if (i >= RANDOM_ITEMS - TAIL_CALM) idle_on = 1'b0;
			// a long run of appends drives the count into saturation
			if (i == 400) append_run = 135;
			if (i == 800) begin
				start <= 1'b0;
				wait (pending_results.size() == 0);
				@(posedge clk);
			end
			if (append_run > 0) begin
				it.cmd = CMD_APPEND;
				it.node = NODE_W'($urandom_range(0, 63));
				it.build_count = BC_W'($urandom_range(0, 127));
				append_run--;
			end else begin
				it = random_command();
			end
			gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
			send_command(it, gap, 1'b0, '0);
		end

		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (300) @(posedge clk);

		$display("ran %0d commands: %0d builds, %0d appends, %0d removes, %0d pops",
			results_seen, n_builds, n_appends, n_removes, n_pops);
		$display("%0d misses on remove, %0d on an empty list, longest count %0d, %0d mismatches",
			n_not_found, n_empty, peak_len, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[linked_list_node_pool_engine_core.f]
src/llnpe_pkg.sv
src/llnpe_ram.sv
src/linked_list_node_pool_engine_core.sv
verif/tb_linked_list_node_pool_engine_core.sv
